### design/sawarq_pkg.sv
// ----------------------------------------------------------------------------
// sawarq_pkg
// Shared types and constants of the stop-and-wait ARQ engine.
// ----------------------------------------------------------------------------
package sawarq_pkg;

	localparam int SEQ_W     = 16;
	localparam int LEN_W     = 9;
	localparam int RETRY_W   = 8;
	localparam int TIMER_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int IN_W      = 32;
	localparam int OUT_W     = 32;

	localparam int MAX_PAYLOAD   = 256;
	localparam int MAX_PAYLOAD_W = 13;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [RETRY_W-1:0] RETRIES_RST = 8'd3;
	localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd100;
	localparam logic [LEN_W-1:0]   RXLEN_RST   = 9'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RETRY_LIMIT = 2'd0,
		REG_ACK_TIMEOUT = 2'd1,
		REG_MAX_RX_LEN  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_SEND   = 2'd0,
		CMD_FRAME  = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_TXFAIL = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_REQUEST  = 3'd0,
		KIND_RESPONSE = 3'd1,
		KIND_ACK      = 3'd2,
		KIND_NACK     = 3'd3
	} frame_kind_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_REQ     = 3'd1,
		ACT_ACK     = 3'd2,
		ACT_NACK    = 3'd3,
		ACT_DELIVER = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_ACKED     = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_BUSY      = 3'd4
	} status_t;

	// classified event handed from the front to the back
	typedef struct packed {
		cmd_t             cmd;
		logic [SEQ_W-1:0] seq;
		logic             fvalid;
		logic             is_ack;
		logic             is_data;
		logic             too_large;
		logic [LEN_W-1:0] len;
	} evt_t;

endpackage

### design/sawarq_front.sv
// ----------------------------------------------------------------------------
// sawarq_front
// Unpacks an input item and classifies the frame fields into an event.
// ----------------------------------------------------------------------------
module sawarq_front (
	input  logic [1:0]                    s_tuser, // command
	input  logic [sawarq_pkg::IN_W-1:0]   s_tdata, // frame_seq, frame_kind, frame_valid,
	                                               // frame_len, zero fill
	input  logic [sawarq_pkg::LEN_W-1:0]  max_receive_len,
	output sawarq_pkg::evt_t              evt
);
	import sawarq_pkg::*;

	logic [SEQ_W-1:0] seq;
	logic [2:0]       kind;
	logic             fvalid;
	logic [LEN_W-1:0] len;

	assign seq    = s_tdata[15:0];
	assign kind   = s_tdata[18:16];
	assign fvalid = s_tdata[19];
	assign len    = s_tdata[28:20];

	always_comb begin
		evt.cmd     = cmd_t'(s_tuser);
		evt.seq     = seq;
		evt.fvalid  = fvalid;
		evt.is_ack  = fvalid && (kind == KIND_ACK);
		evt.is_data = (kind == KIND_REQUEST) || (kind == KIND_RESPONSE);
		evt.len     = len;
		// the user is to hold limits static while items are in flight (the block does not enforce it), so judge size here
		evt.too_large = (len > max_receive_len) ||
			({{(MAX_PAYLOAD_W-LEN_W){1'b0}}, len} > MAX_PAYLOAD_W'(MAX_PAYLOAD));
	end

endmodule

### design/sawarq_queue.sv
// ----------------------------------------------------------------------------
// sawarq_queue
// Short event queue between the classifying front and the protocol back.
// ----------------------------------------------------------------------------
module sawarq_queue #(
	parameter int DEPTH = sawarq_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sawarq_pkg::evt_t  push_evt,
	output logic              not_full,
	input  logic              pop,
	output logic              not_empty,
	output sawarq_pkg::evt_t  head
);
	import sawarq_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	evt_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_full  = (count_q != CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

### design/sawarq_back.sv
// ----------------------------------------------------------------------------
// sawarq_back
// Protocol state of the link: send/ack tracking, retransmit and receive check.
// ----------------------------------------------------------------------------
module sawarq_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	input  sawarq_pkg::evt_t               evt,
	output logic                           pop,
	input  logic [sawarq_pkg::RETRY_W-1:0] retry_limit,
	input  logic [sawarq_pkg::TIMER_W-1:0] ack_timeout_ticks,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sawarq_pkg::OUT_W-1:0]   m_tdata // action, out_seq, deliver_len, status,
	                                               // zero fill
);
	import sawarq_pkg::*;

	logic [SEQ_W-1:0]   send_seq_q, send_seq_n;
	logic [RETRY_W-1:0] attempt_q, attempt_n;
	logic               awaiting_q, awaiting_n;
	logic [TIMER_W-1:0] timer_q, timer_n;
	logic [SEQ_W-1:0]   last_rx_q, last_rx_n;
	logic               rx_started_q, rx_started_n;

	logic               out_valid_q;
	action_t            act_q;
	logic [SEQ_W-1:0]   oseq_q;
	logic [LEN_W-1:0]   dlen_q;
	status_t            st_q;

	action_t            act;
	logic [SEQ_W-1:0]   oseq;
	logic [LEN_W-1:0]   dlen;
	status_t            st;
	logic [SEQ_W-1:0]   last_eff;
	logic               do_rtx;

	assign pop      = evt_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, st_q, dlen_q, oseq_q, act_q};

	always_comb begin
		send_seq_n   = send_seq_q;
		attempt_n    = attempt_q;
		awaiting_n   = awaiting_q;
		timer_n      = timer_q;
		last_rx_n    = last_rx_q;
		rx_started_n = rx_started_q;
		act          = ACT_NONE;
		oseq         = '0;
		dlen         = '0;
		st           = ST_NONE;
		do_rtx       = 1'b0;
		// first data frame makes itself the expected one
		last_eff     = rx_started_q ? last_rx_q : evt.seq - 1'b1;

		case (evt.cmd)
			CMD_SEND: begin
				oseq = send_seq_q;
				if (awaiting_q) begin
					st = ST_BUSY;
				end else begin
					awaiting_n = 1'b1;
					attempt_n  = '0;
					timer_n    = ack_timeout_ticks;
					act        = ACT_REQ;
				end
			end
			CMD_FRAME: begin
				if (awaiting_q) begin
					if (evt.is_ack && (evt.seq == send_seq_q)) begin
						send_seq_n = send_seq_q + 1'b1;
						awaiting_n = 1'b0;
						oseq       = send_seq_q;
						st         = ST_ACKED;
					end else begin
						do_rtx = 1'b1;
					end
				end else if (!evt.fvalid) begin
					act  = ACT_NACK;
					oseq = evt.seq;
				end else if (evt.is_data) begin
					rx_started_n = 1'b1;
					last_rx_n    = last_eff;
					oseq         = evt.seq;
					if (evt.seq == last_eff + 1'b1) begin
						if (evt.too_large) begin
							st = ST_TOO_LARGE;
						end else begin
							last_rx_n = evt.seq;
							act       = ACT_DELIVER;
							dlen      = evt.len;
						end
					end else if (evt.seq == last_eff) begin
						act = ACT_ACK;
					end else begin
						act = ACT_NACK;
					end
				end
			end
			CMD_TICK: begin
				if (awaiting_q) begin
					if (timer_q <= TIMER_W'(1)) begin
						timer_n = '0;
						do_rtx  = 1'b1;
					end else begin
						timer_n = timer_q - 1'b1;
					end
				end
			end
			CMD_TXFAIL: begin
				do_rtx = awaiting_q;
			end
			default: begin
			end
		endcase

		if (do_rtx) begin
			oseq = send_seq_q;
			if (attempt_q >= retry_limit) begin
				awaiting_n = 1'b0;
				st         = ST_EXHAUSTED;
			end else begin
				attempt_n = attempt_q + 1'b1;
				timer_n   = ack_timeout_ticks;
				act       = ACT_REQ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_seq_q   <= '0;
			attempt_q    <= '0;
			awaiting_q   <= 1'b0;
			timer_q      <= '0;
			last_rx_q    <= '0;
			rx_started_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				send_seq_q   <= send_seq_n;
				attempt_q    <= attempt_n;
				awaiting_q   <= awaiting_n;
				timer_q      <= timer_n;
				last_rx_q    <= last_rx_n;
				rx_started_q <= rx_started_n;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	// result payload, loaded with every event taken from the queue
	always_ff @(posedge clk) begin
		if (pop) begin
			act_q  <= act;
			oseq_q <= oseq;
			dlen_q <= dlen;
			st_q   <= st;
		end
	end

	a_len_only_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (dlen_q != '0) |-> act_q == ACT_DELIVER)
		else $error("nonzero length without delivery");

	a_send_starts_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (evt.cmd == CMD_SEND) |=> awaiting_q)
		else $error("send did not leave engine waiting for ack");

	a_ack_advances: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (evt.cmd == CMD_FRAME) && awaiting_q && evt.is_ack &&
		(evt.seq == send_seq_q) |=> (send_seq_q == $past(send_seq_q) + 1'b1) && !awaiting_q)
		else $error("matching ack did not advance send sequence");

	a_req_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (act_q == ACT_REQ) |-> st_q == ST_NONE)
		else $error("request carries a status");

endmodule

### design/stop_and_wait_arq_engine.sv
// ----------------------------------------------------------------------------
// stop_and_wait_arq_engine
// Stop-and-wait ARQ control for one link: send tracking and receive check.
// ----------------------------------------------------------------------------
// Each input item (send, received frame, millisecond tick or transmit failure)
// yields exactly one result item. The block takes one item per clock while the
// queue is not full; the item is classified and queued at the accepting edge,
// and the link state and the result register update when the back end pops it,
// which waits while a result is held on the output. The back end's update of
// the link state as it pops each item sets the rate; a queue of QUEUE_DEPTH
// entries lets the input side keep going while a result waits on the output.
// Write the configuration registers only while no items are in flight.
module stop_and_wait_arq_engine #(
	parameter int QUEUE_DEPTH = sawarq_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sawarq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sawarq_pkg::CFG_W-1:0]     cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [1:0]                       s_tuser, // command
	input  logic [sawarq_pkg::IN_W-1:0]      s_tdata, // frame_seq, frame_kind,
	                                                  // frame_valid, frame_len, zero fill
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sawarq_pkg::OUT_W-1:0]     m_tdata  // action, out_seq, deliver_len,
	                                                  // status, zero fill
);
	import sawarq_pkg::*;

	logic [RETRY_W-1:0] retry_limit_q;
	logic [TIMER_W-1:0] ack_timeout_q;
	logic [LEN_W-1:0]   max_rx_len_q;

	evt_t front_evt;
	evt_t head_evt;
	logic q_not_full;
	logic q_not_empty;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRIES_RST;
			ack_timeout_q <= TIMEOUT_RST;
			max_rx_len_q  <= RXLEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RETRY_LIMIT: retry_limit_q <= cfg_data[RETRY_W-1:0];
				REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[TIMER_W-1:0];
				REG_MAX_RX_LEN:  max_rx_len_q  <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready = q_not_full;

	sawarq_front u_front (
		.s_tuser         (s_tuser),
		.s_tdata         (s_tdata),
		.max_receive_len (max_rx_len_q),
		.evt             (front_evt)
	);

	sawarq_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && q_not_full),
		.push_evt  (front_evt),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_evt)
	);

	sawarq_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.evt_valid         (q_not_empty),
		.evt               (head_evt),
		.pop               (q_pop),
		.retry_limit       (retry_limit_q),
		.ack_timeout_ticks (ack_timeout_q),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata)
	);

endmodule
